// ===== src/running_median_tracker_top_macros.svh =====
// Assertion macros for the running median tracker.
`ifndef RUNNING_MEDIAN_TRACKER_TOP_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rmt_pkg.sv =====
// Shared types for the running median tracker.
package rmt_pkg;

    typedef struct packed {
        logic gt;   // stored value above the new sample, or cell empty
        logic hit;  // cell sits at one of the two middle positions
    } t_cell_flags;

endpackage

// ===== src/rmt_if.sv =====
// Sample and result channel interfaces of the running median tracker.
interface rmt_smp_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface rmt_res_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int HELD_BITS   = 7
) ();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] median_twice;
    logic [HELD_BITS-1:0]        samples_held;
    logic                        rejected;

    modport source (output valid, output median_twice, output samples_held,
                    output rejected, input ready);
    modport sink (input valid, input median_twice, input samples_held,
                  input rejected, output ready);
endinterface

// ===== src/rmt_cell.sv =====
// One cell of the sorted insertion row: holds one sample, shifts up on insert.
module rmt_cell #(
    parameter int IDX         = 0,
    parameter int CW          = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic [CW-1:0]                 i_count,
    input  logic [CW-1:0]                 i_lo_idx,
    input  logic [CW-1:0]                 i_hi_idx,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_val,
    input  logic                          i_prev_gt,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output rmt_pkg::t_cell_flags          o_flags,
    output logic [SAMPLE_BITS-1:0]        o_lo,
    output logic [SAMPLE_BITS-1:0]        o_hi
);
    import rmt_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic                          occ;
    logic                          gt;
    logic                          sel_lo;
    logic                          sel_hi;

    assign occ    = MY_IDX < i_count;
    assign gt     = !occ || (r_val > i_x);
    assign sel_lo = MY_IDX == i_lo_idx;
    assign sel_hi = MY_IDX == i_hi_idx;

    // take the lower neighbor if it moves up too, else the new sample lands here
    assign n_val = i_prev_gt ? i_prev_val : i_x;

    always_ff @(posedge i_clk) begin
        if (i_wr && gt) begin
            r_val <= n_val;
        end
    end

    assign o_val       = r_val;
    assign o_flags.gt  = gt;
    assign o_flags.hit = sel_lo || sel_hi;
    assign o_lo        = sel_lo ? r_val : '0;
    assign o_hi        = sel_hi ? r_val : '0;
endmodule

// ===== src/running_median_tracker_top.sv =====
// Top level of the running median tracker: cell row, middle taps, result register.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_smp    | in  | sample                                    | valid/ready
//  o_res    | out | median_twice, samples_held, rejected      | valid/ready
//
// Flow: one request per cycle sustained while the result is not stalled. The
// accepting edge inserts the sample into the cell row; then, once the result
// register is free, the two middle cells are ORed onto taps and their sum registered.
// Reset clears the fill count and handshake state; cell contents are not cleared.
// A stalled result holds the second stage, which then holds off new requests.
`include "running_median_tracker_top_macros.svh"

module running_median_tracker_top #(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    rmt_smp_if.sink     i_smp,
    rmt_res_if.source   o_res
);
    import rmt_pkg::*;

    localparam int              CW    = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0]   CAP_W = CW'(CAPACITY);

    logic [CW-1:0]                 r_count;
    logic                          r_busy;
    logic                          r_rej;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS:0]   r_med;
    logic [CW-1:0]                 r_held;
    logic                          r_out_rej;

    logic                          full;
    logic                          acc;
    logic                          fin;
    logic                          wr;
    logic [CW-1:0]                 lo_idx;
    logic [CW-1:0]                 hi_idx;
    logic [SAMPLE_BITS-1:0]        tap_lo;
    logic [SAMPLE_BITS-1:0]        tap_hi;
    logic signed [SAMPLE_BITS:0]   n_med;

    logic signed [SAMPLE_BITS-1:0] cell_val [CAPACITY];
    logic [SAMPLE_BITS-1:0]        cell_lo  [CAPACITY];
    logic [SAMPLE_BITS-1:0]        cell_hi  [CAPACITY];
    t_cell_flags                   cell_flags [CAPACITY];
    logic [CAPACITY-1:0]           gt_vec;
    logic [CAPACITY-1:0]           hit_vec;

    assign full        = r_count == CAP_W;
    assign acc         = i_smp.valid && i_smp.ready;
    assign fin         = r_busy && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_busy || fin;
    assign wr          = acc && !full;

    // middle positions of the row as it stands after the insert
    assign lo_idx = (r_count - CW'(1)) >> 1;
    assign hi_idx = r_count >> 1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_val;
        logic                          prev_gt;

        if (g == 0) begin : g_head
            assign prev_val = i_smp.sample;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_val = cell_val[g-1];
            assign prev_gt  = cell_flags[g-1].gt;
        end

        rmt_cell #(
            .IDX         (g),
            .CW          (CW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_wr       (wr),
            .i_count    (r_count),
            .i_lo_idx   (lo_idx),
            .i_hi_idx   (hi_idx),
            .i_x        (i_smp.sample),
            .i_prev_val (prev_val),
            .i_prev_gt  (prev_gt),
            .o_val      (cell_val[g]),
            .o_flags    (cell_flags[g]),
            .o_lo       (cell_lo[g]),
            .o_hi       (cell_hi[g])
        );

        assign gt_vec[g]  = cell_flags[g].gt;
        assign hit_vec[g] = cell_flags[g].hit;
    end

    always_comb begin
        tap_lo = '0;
        tap_hi = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tap_lo = tap_lo | cell_lo[i];
            tap_hi = tap_hi | cell_hi[i];
        end
    end

    assign n_med = $signed({tap_lo[SAMPLE_BITS-1], tap_lo})
                 + $signed({tap_hi[SAMPLE_BITS-1], tap_hi});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr) begin
                r_count <= r_count + CW'(1);
            end
            if (acc) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rej <= full;
        end
        if (fin) begin
            r_med     <= n_med;
            r_held    <= r_count;
            r_out_rej <= r_rej;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.median_twice = r_med;
    assign o_res.samples_held = r_held;
    assign o_res.rejected     = r_out_rej;

    `RMT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_W,
                    "fill count above capacity")
    `RMT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, wr, r_count == $past(r_count) + CW'(1),
                     "fill count missed an insert")
    `RMT_ASSERT_NOW(a_gt_monotone, i_clk, i_rst_n, 1'b1, ((gt_vec << 1) & ~gt_vec) == '0,
                    "cell row out of order")
    `RMT_ASSERT_NOW(a_middle_taps, i_clk, i_rst_n, r_busy,
                    $countones(hit_vec) == 1 || $countones(hit_vec) == 2,
                    "middle taps not selected")
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for running_median_tracker_top: random samples, random stalls.
module testbench;

    localparam int CAPACITY    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int HELD_BITS   = 7;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_CYCLES  = 200000;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic signed [SAMPLE_BITS:0] median_twice;
        logic [HELD_BITS-1:0]        samples_held;
        logic                        rejected;
    } median_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        bit                     drain;
    } feed_t;

    logic i_clk;
    logic i_rst_n;

    rmt_smp_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_ch ();
    rmt_res_if #(.SAMPLE_BITS(SAMPLE_BITS), .HELD_BITS(HELD_BITS)) res_ch ();

    running_median_tracker_top #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch.sink),
        .o_res   (res_ch.source)
    );

    feed_t                         sample_queue[$];
    median_t                       median_due[$];
    logic signed [SAMPLE_BITS-1:0] sorted_vals[CAPACITY];
    int                            held_n;
    int                            sent_cnt;
    int                            rcvd_cnt;
    int                            err_cnt;
    int                            src_wait;
    int                            snk_wait;
    int                            hold_left;
    int                            hold_mark;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report(input string what);
        if (err_cnt < MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        err_cnt++;
    endtask

    // sorted insertion; a full store drops the sample and keeps its median
    task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int                          i;
        median_t                     r;
        logic signed [SAMPLE_BITS:0] lo;
        logic signed [SAMPLE_BITS:0] hi;
        r.rejected = (held_n >= CAPACITY);
        if (!r.rejected) begin
            i = held_n;
            while (i > 0 && sorted_vals[i-1] > s) begin
                sorted_vals[i] = sorted_vals[i-1];
                i--;
            end
            sorted_vals[i] = s;
            held_n++;
        end
        if (held_n == 0) begin
            r.median_twice = '0;
        end else if (held_n % 2 == 1) begin
            lo = sorted_vals[held_n / 2];
            r.median_twice = lo + lo;
        end else begin
            lo = sorted_vals[held_n / 2 - 1];
            hi = sorted_vals[held_n / 2];
            r.median_twice = lo + hi;
        end
        r.samples_held = held_n[HELD_BITS-1:0];
        median_due.push_back(r);
    endtask

    task automatic add_value(input logic [SAMPLE_BITS-1:0] v);
        feed_t f;
        f.value = v;
        f.drain = 1'b0;
        sample_queue.push_back(f);
    endtask

    task automatic add_drain();
        feed_t f;
        f.value = '0;
        f.drain = 1'b1;
        sample_queue.push_back(f);
    endtask

    always @(posedge i_clk) begin : source_side
        int    gap;
        feed_t nxt;
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
            smp_ch.sample <= '0;
            src_wait <= 0;
            sent_cnt <= 0;
        end else if (!smp_ch.valid || smp_ch.ready) begin
            gap = src_wait;
            if (smp_ch.valid) begin
                sent_cnt <= sent_cnt + 1;
                gap = ((sent_cnt / 50) % 3 == 1) ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                smp_ch.valid <= 1'b0;
                src_wait <= gap - 1;
            end else if (sample_queue.size() > 0 && sample_queue[0].drain) begin
                // hold off until every result is back
                smp_ch.valid <= 1'b0;
                src_wait <= 0;
                if (!smp_ch.valid && sent_cnt == rcvd_cnt) begin
                    nxt = sample_queue.pop_front();
                end
            end else if (sample_queue.size() > 0) begin
                nxt = sample_queue.pop_front();
                smp_ch.valid <= 1'b1;
                smp_ch.sample <= nxt.value;
                src_wait <= 0;
            end else begin
                smp_ch.valid <= 1'b0;
                src_wait <= 0;
            end
        end
    end

    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_mark <= -1;
        end else if ((sent_cnt == 40 || sent_cnt == 400) && sent_cnt != hold_mark) begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= sent_cnt;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : sink_side
        int stall;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_wait <= 0;
        end else begin
            stall = snk_wait;
            if (res_ch.valid && res_ch.ready) begin
                stall = ((rcvd_cnt / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                snk_wait <= stall;
            end else if (stall > 0) begin
                res_ch.ready <= 1'b0;
                snk_wait <= stall - 1;
            end else begin
                res_ch.ready <= 1'b1;
                snk_wait <= 0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        median_t want;
        if (!i_rst_n) begin
            rcvd_cnt <= 0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                take_sample(smp_ch.sample);
            end
            if (res_ch.valid && res_ch.ready) begin
                rcvd_cnt <= rcvd_cnt + 1;
                if (median_due.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    want = median_due.pop_front();
                    if (res_ch.median_twice !== want.median_twice) begin
                        report($sformatf("median_twice got %0d want %0d",
                                         res_ch.median_twice, want.median_twice));
                    end
                    if (res_ch.samples_held !== want.samples_held) begin
                        report($sformatf("samples_held got %0d want %0d",
                                         res_ch.samples_held, want.samples_held));
                    end
                    if (res_ch.rejected !== want.rejected) begin
                        report($sformatf("rejected got %0b want %0b",
                                         res_ch.rejected, want.rejected));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        held_n = 0;
        err_cnt = 0;
        // extremes, signs, equal values, alternating bit patterns
        add_value(16'sd32767);
        add_value(-16'sd32768);
        add_value(16'sd0);
        add_value(-16'sd1);
        add_value(16'sd1);
        add_value(-16'sd32768);
        add_value(-16'sd32768);
        add_value(16'sd32767);
        add_value(16'sd32767);
        add_value(16'sd7);
        add_value(16'sd7);
        add_value(16'sd7);
        add_value(-16'sd7);
        add_value(16'sd0);
        add_value(16'h5555);
        add_value(16'hAAAA);
        add_drain();
        // fill the store; narrow values give many duplicates
        for (int k = 0; k < CAPACITY - 16; k++) begin
            if (k % 2 == 0) begin
                add_value(SAMPLE_BITS'($urandom_range(0, 15)) - 16'd8);
            end else begin
                add_value(SAMPLE_BITS'($urandom_range(0, 65535)));
            end
        end
        add_drain();
        // store full from here on
        add_value(-16'sd32768);
        add_value(16'sd32767);
        add_value(16'sd0);
        for (int k = 0; k < 633; k++) begin
            if (k == 300) begin
                add_drain();
            end
            add_value(SAMPLE_BITS'($urandom_range(0, 65535)));
        end

        @(posedge i_rst_n);
        do @(negedge i_clk);
        while (sample_queue.size() > 0 || smp_ch.valid || sent_cnt != rcvd_cnt);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (median_due.size() > 0) begin
            report($sformatf("%0d results never arrived", median_due.size()));
        end
        if (err_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(4 * MAX_CYCLES);
        $display("testbench failed");
        $finish;
    end

endmodule
